>>> rtl/kcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock controller: event and
// result payloads, status and event codes, entry phases, register indexes.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // number of digits in one code
  localparam int unsigned CodeDigits = 8;
  localparam int unsigned PosW       = (CodeDigits > 1) ? $clog2(CodeDigits) : 1;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned CountW     = 4;
  localparam int unsigned TicksW     = 16;
  localparam int unsigned CfgIdxW    = 2;

  // reset value of every stored code digit
  localparam logic [DigitW-1:0] CodeResetDigit = 4'h1;

  // register reset values
  localparam logic [CountW-1:0] MaxAttemptsRst  = 4'd3;
  localparam logic [TicksW-1:0] LockoutTicksRst = 16'd900;
  localparam logic [TicksW-1:0] PenaltyTicksRst = 16'd5;
  localparam logic [TicksW-1:0] UnlockTicksRst  = 16'd1;

  // failure count ceiling
  localparam logic [CountW-1:0] FailMax = 4'd15;

  // event kinds
  typedef enum logic [1:0] {
    KindDigit = 2'd0,
    KindReset = 2'd1,
    KindTick  = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [3:0] {
    StTaken    = 4'd0,
    StBusy     = 4'd1,
    StUnlocked = 4'd2,
    StWrong    = 4'd3,
    StLocked   = 4'd4,
    StResetIn  = 4'd5,
    StOldWrong = 4'd6,
    StEnterNew = 4'd7,
    StConfirm  = 4'd8,
    StDone     = 4'd9,
    StConfBad  = 4'd10,
    StNoReset  = 4'd11,
    StTick     = 4'd12
  } status_e;

  // entry phase, one-hot
  typedef enum logic [3:0] {
    PhNormal  = 4'b0001,
    PhVerify  = 4'b0010,
    PhNew     = 4'b0100,
    PhConfirm = 4'b1000
  } phase_e;

  // mode codes reported on the result
  typedef enum logic [1:0] {
    ModeNormal  = 2'd0,
    ModeVerify  = 2'd1,
    ModeNew     = 2'd2,
    ModeConfirm = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxAttempts  = 2'd0,
    CfgLockoutTicks = 2'd1,
    CfgPenaltyTicks = 2'd2,
    CfgUnlockTicks  = 2'd3
  } cfg_idx_e;

  // one input event
  typedef struct packed {
    logic [1:0]        kind;
    logic [DigitW-1:0] digit;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [3:0]        status;
    logic              relay_closed;
    logic [CountW-1:0] digits_entered;
    logic [1:0]        mode;
    logic [CountW-1:0] fail_count;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/keypad_code_lock_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_code_lock_controller
// Code lock with attempt counting, penalty and lockout waits, relay hold time
// and a code change sequence (old code, new code, confirmation).
// ----------------------------------------------------------------------------
// Each event (digit, reset button press or time tick) gives exactly one
// result. An event is registered on transfer, processed by the state update
// logic once the result register is free or being read, and then lands in
// the result register. One event can be taken every cycle; the rate drops
// only while a result waits on the output side. Configuration writes are
// always taken and should be issued only while no event is in flight.
module keypad_code_lock_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // event channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire kcl_pkg::in_item_t                  in_item_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output kcl_pkg::out_item_t                      out_item_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [kcl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [kcl_pkg::TicksW-1:0]         cfg_data_i
);

  // configuration registers
  logic [kcl_pkg::CountW-1:0] max_attempts_q;
  logic [kcl_pkg::TicksW-1:0] lockout_ticks_q;
  logic [kcl_pkg::TicksW-1:0] penalty_ticks_q;
  logic [kcl_pkg::TicksW-1:0] unlock_ticks_q;

  // input register
  logic              in_valid_q;
  kcl_pkg::in_item_t in_item_q;

  // result register
  logic               out_valid_q;
  kcl_pkg::out_item_t out_item_q, out_item_d;

  // lock state
  logic [kcl_pkg::DigitW-1:0] stored_code_q [kcl_pkg::CodeDigits];
  logic [kcl_pkg::DigitW-1:0] new_code_q    [kcl_pkg::CodeDigits];
  logic [kcl_pkg::PosW-1:0]   pos_q, pos_d;
  logic                       mism_q, mism_d;
  kcl_pkg::phase_e            phase_q, phase_d;
  logic [kcl_pkg::CountW-1:0] fail_q, fail_d;
  logic [kcl_pkg::TicksW-1:0] timer_q, timer_d;
  logic                       lockout_q, lockout_d;
  logic                       relay_q, relay_d;

  logic                       proc_fire;
  logic                       new_wr;
  logic                       copy_en;
  logic                       busy;
  logic                       last_pos;
  logic                       mism_now;
  logic [kcl_pkg::DigitW-1:0] ref_digit;
  logic [kcl_pkg::CountW-1:0] fail_inc;
  logic [kcl_pkg::TicksW-1:0] timer_dec;
  kcl_pkg::status_e           status;
  kcl_pkg::mode_e             mode;

  // handshake control
  assign proc_fire   = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc_fire;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q  <= kcl_pkg::MaxAttemptsRst;
      lockout_ticks_q <= kcl_pkg::LockoutTicksRst;
      penalty_ticks_q <= kcl_pkg::PenaltyTicksRst;
      unlock_ticks_q  <= kcl_pkg::UnlockTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (kcl_pkg::cfg_idx_e'(cfg_index_i))
        kcl_pkg::CfgMaxAttempts:  max_attempts_q  <= cfg_data_i[kcl_pkg::CountW-1:0];
        kcl_pkg::CfgLockoutTicks: lockout_ticks_q <= cfg_data_i;
        kcl_pkg::CfgPenaltyTicks: penalty_ticks_q <= cfg_data_i;
        kcl_pkg::CfgUnlockTicks:  unlock_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // helper terms for the event
  assign busy      = lockout_q || (timer_q != '0);
  assign last_pos  = (pos_q == kcl_pkg::PosW'(kcl_pkg::CodeDigits - 1));
  assign ref_digit = (phase_q == kcl_pkg::PhConfirm) ? new_code_q[pos_q] : stored_code_q[pos_q];
  assign mism_now  = mism_q || (ref_digit != in_item_q.digit);
  assign fail_inc  = (fail_q == kcl_pkg::FailMax) ? kcl_pkg::FailMax : fail_q + 1'b1;
  assign timer_dec = timer_q - 1'b1;

  // event processing
  always_comb begin
    pos_d     = pos_q;
    mism_d    = mism_q;
    phase_d   = phase_q;
    fail_d    = fail_q;
    timer_d   = timer_q;
    lockout_d = lockout_q;
    relay_d   = relay_q;
    new_wr    = 1'b0;
    copy_en   = 1'b0;
    status    = kcl_pkg::StBusy;
    case (kcl_pkg::kind_e'(in_item_q.kind))
      kcl_pkg::KindTick: begin
        status = kcl_pkg::StTick;
        if (timer_q != '0) begin
          timer_d = timer_dec;
          if (timer_dec == '0) begin
            relay_d = 1'b0;
            if (lockout_q) begin
              lockout_d = 1'b0;
              fail_d    = '0;
            end
          end
        end
      end
      kcl_pkg::KindReset: begin
        if (lockout_q) begin
          status = kcl_pkg::StNoReset;
        end else if (busy || phase_q != kcl_pkg::PhNormal) begin
          status = kcl_pkg::StBusy;
        end else begin
          phase_d = kcl_pkg::PhVerify;
          pos_d   = '0;
          mism_d  = 1'b0;
          status  = kcl_pkg::StResetIn;
        end
      end
      kcl_pkg::KindDigit: begin
        if (busy) begin
          status = kcl_pkg::StBusy;
        end else begin
          pos_d = last_pos ? '0 : pos_q + 1'b1;
          if (phase_q == kcl_pkg::PhNew) begin
            // new code entry
            new_wr = 1'b1;
            if (last_pos) begin
              phase_d = kcl_pkg::PhConfirm;
              mism_d  = 1'b0;
              status  = kcl_pkg::StConfirm;
            end else begin
              status = kcl_pkg::StTaken;
            end
          end else if (!last_pos) begin
            mism_d = mism_now;
            status = kcl_pkg::StTaken;
          end else begin
            // full attempt: act on the comparison
            mism_d = 1'b0;
            case (phase_q)
              kcl_pkg::PhNormal: begin
                if (!mism_now) begin
                  fail_d  = '0;
                  timer_d = unlock_ticks_q;
                  relay_d = (unlock_ticks_q != '0);
                  status  = kcl_pkg::StUnlocked;
                end else if (fail_inc >= max_attempts_q) begin
                  timer_d   = lockout_ticks_q;
                  lockout_d = (lockout_ticks_q != '0);
                  fail_d    = (lockout_ticks_q != '0) ? fail_inc : '0;
                  status    = kcl_pkg::StLocked;
                end else begin
                  fail_d  = fail_inc;
                  timer_d = penalty_ticks_q;
                  status  = kcl_pkg::StWrong;
                end
              end
              kcl_pkg::PhVerify: begin
                if (mism_now) begin
                  phase_d = kcl_pkg::PhNormal;
                  timer_d = penalty_ticks_q;
                  status  = kcl_pkg::StOldWrong;
                end else begin
                  phase_d = kcl_pkg::PhNew;
                  status  = kcl_pkg::StEnterNew;
                end
              end
              default: begin
                // confirmation pass
                phase_d = kcl_pkg::PhNormal;
                if (mism_now) begin
                  timer_d = penalty_ticks_q;
                  status  = kcl_pkg::StConfBad;
                end else begin
                  copy_en = 1'b1;
                  status  = kcl_pkg::StDone;
                end
              end
            endcase
          end
        end
      end
      default: status = kcl_pkg::StBusy;
    endcase
  end

  // mode code from phase
  always_comb begin
    case (phase_d)
      kcl_pkg::PhNormal:  mode = kcl_pkg::ModeNormal;
      kcl_pkg::PhVerify:  mode = kcl_pkg::ModeVerify;
      kcl_pkg::PhNew:     mode = kcl_pkg::ModeNew;
      kcl_pkg::PhConfirm: mode = kcl_pkg::ModeConfirm;
      default:            mode = kcl_pkg::ModeNormal;
    endcase
  end

  // result assembly
  always_comb begin
    out_item_d.status         = status;
    out_item_d.relay_closed   = relay_d;
    out_item_d.digits_entered = kcl_pkg::CountW'(pos_d);
    out_item_d.mode           = mode;
    out_item_d.fail_count     = fail_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      mism_q    <= 1'b0;
      phase_q   <= kcl_pkg::PhNormal;
      fail_q    <= '0;
      timer_q   <= '0;
      lockout_q <= 1'b0;
      relay_q   <= 1'b0;
    end else if (proc_fire) begin
      pos_q     <= pos_d;
      mism_q    <= mism_d;
      phase_q   <= phase_d;
      fail_q    <= fail_d;
      timer_q   <= timer_d;
      lockout_q <= lockout_d;
      relay_q   <= relay_d;
    end
  end

  // stored code, copied from the new code on a confirmed change
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kcl_pkg::CodeDigits; i++) begin
        stored_code_q[i] <= kcl_pkg::CodeResetDigit;
      end
    end else if (proc_fire && copy_en) begin
      for (int i = 0; i < kcl_pkg::CodeDigits; i++) begin
        stored_code_q[i] <= new_code_q[i];
      end
    end
  end

  // new code digits, no reset
  always_ff @(posedge clk_i) begin
    if (proc_fire && new_wr) begin
      new_code_q[pos_q] <= in_item_q.digit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_item_q <= out_item_d;
    end
  end

  // relay only closed while its hold timer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q |-> (timer_q != '0))
    else $error("relay closed with hold timer at zero");

  // lockout only while its wait runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lockout_q |-> (timer_q != '0))
    else $error("lockout with wait timer at zero");

  // relay and lockout never together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(relay_q && lockout_q))
    else $error("relay closed during lockout");

  // a held event stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_item_q)))
    else $error("pending event lost from input register");

endmodule
`default_nettype wire

>>> sim/kcl_lock_model_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_model_pkg
// Cycle-free behavioral model of the code lock: the lock state, register
// writes and the effect of one event. The checker uses it to predict each
// result, and the stimulus side uses its own copy to steer code entry.
// ----------------------------------------------------------------------------
package kcl_lock_model_pkg;

  import kcl_pkg::*;

  // event kind with no function in the block
  localparam logic [1:0] KindUnused = 2'd3;

  // full lock state plus the register copies
  typedef struct packed {
    logic [CodeDigits-1:0][DigitW-1:0] code;
    logic [CodeDigits-1:0][DigitW-1:0] fresh;
    logic [CountW-1:0]                 pos;
    logic                              miss;
    logic [1:0]                        mode;
    logic [CountW-1:0]                 fails;
    logic [TicksW-1:0]                 timer;
    logic                              locked;
    logic                              relay;
    logic [CountW-1:0]                 max_att;
    logic [TicksW-1:0]                 lock_len;
    logic [TicksW-1:0]                 pen_len;
    logic [TicksW-1:0]                 hold_len;
  } lock_state_t;

  // state right after reset
  function automatic lock_state_t lock_power_up();
    lock_state_t s;
    s          = '0;
    s.code     = {CodeDigits{CodeResetDigit}};
    s.mode     = ModeNormal;
    s.max_att  = MaxAttemptsRst;
    s.lock_len = LockoutTicksRst;
    s.pen_len  = PenaltyTicksRst;
    s.hold_len = UnlockTicksRst;
    return s;
  endfunction

  // one register write
  function automatic lock_state_t lock_write_reg(lock_state_t s, logic [CfgIdxW-1:0] idx,
                                                 logic [TicksW-1:0] value);
    case (idx)
      CfgMaxAttempts:  s.max_att  = value[CountW-1:0];
      CfgLockoutTicks: s.lock_len = value;
      CfgPenaltyTicks: s.pen_len  = value;
      CfgUnlockTicks:  s.hold_len = value;
      default: ;
    endcase
    return s;
  endfunction

  // digits and reset presses are refused while a wait runs
  function automatic logic lock_busy(lock_state_t s);
    return s.locked || (s.timer != '0);
  endfunction

  // apply one event, return the result it produces
  function automatic out_item_t lock_advance(inout lock_state_t s, input in_item_t ev);
    logic              busy;
    logic              bad;
    logic [DigitW-1:0] want;
    status_e           st;
    out_item_t         res;
    busy = lock_busy(s);
    st   = StBusy;
    case (ev.kind)
      KindTick: begin
        // count the wait down, release relay and lockout at zero
        if (s.timer != '0) begin
          s.timer = s.timer - 1'b1;
          if (s.timer == '0) begin
            s.relay = 1'b0;
            if (s.locked) begin
              s.locked = 1'b0;
              s.fails  = '0;
            end
          end
        end
        st = StTick;
      end
      KindReset: begin
        if (s.locked) st = StNoReset;
        else if (!busy && s.mode == ModeNormal) begin
          s.mode = ModeVerify;
          s.pos  = '0;
          s.miss = 1'b0;
          st     = StResetIn;
        end
      end
      KindDigit: begin
        if (!busy && s.mode == ModeNew) begin
          // new code entry only records
          s.fresh[s.pos] = ev.digit;
          s.pos = s.pos + 1'b1;
          if (s.pos == CodeDigits) begin
            s.pos  = '0;
            s.mode = ModeConfirm;
            s.miss = 1'b0;
            st     = StConfirm;
          end else st = StTaken;
        end else if (!busy) begin
          want = (s.mode == ModeConfirm) ? s.fresh[s.pos] : s.code[s.pos];
          if (want != ev.digit) s.miss = 1'b1;
          s.pos = s.pos + 1'b1;
          if (s.pos != CodeDigits) st = StTaken;
          else begin
            // entry complete, judge it
            s.pos  = '0;
            bad    = s.miss;
            s.miss = 1'b0;
            case (s.mode)
              ModeNormal: begin
                if (!bad) begin
                  s.fails = '0;
                  s.timer = s.hold_len;
                  s.relay = (s.timer != '0);
                  st      = StUnlocked;
                end else begin
                  if (s.fails != FailMax) s.fails = s.fails + 1'b1;
                  if (s.fails >= s.max_att) begin
                    s.timer  = s.lock_len;
                    s.locked = (s.timer != '0);
                    if (!s.locked) s.fails = '0;
                    st = StLocked;
                  end else begin
                    s.timer = s.pen_len;
                    st      = StWrong;
                  end
                end
              end
              ModeVerify: begin
                if (bad) begin
                  s.mode  = ModeNormal;
                  s.timer = s.pen_len;
                  st      = StOldWrong;
                end else begin
                  s.mode = ModeNew;
                  st     = StEnterNew;
                end
              end
              default: begin
                s.mode = ModeNormal;
                if (bad) begin
                  s.timer = s.pen_len;
                  st      = StConfBad;
                end else begin
                  s.code = s.fresh;
                  st     = StDone;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.status         = st;
    res.relay_closed   = s.relay;
    res.digits_entered = s.pos;
    res.mode           = s.mode;
    res.fail_count     = s.fails;
    return res;
  endfunction

endpackage

>>> sim/kcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_checker
// Passive checker for the code lock: follows register writes and event
// transfers, predicts one result per event and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kcl_checker
  import kcl_pkg::*;
  import kcl_lock_model_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire in_item_t           in_item_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire out_item_t          out_item_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TicksW-1:0]  cfg_data_i,
  output int unsigned             pending_o,
  output int unsigned             errors_o
);

  lock_state_t lock_model;
  out_item_t   results_due[$];
  out_item_t   due;
  int unsigned mismatches = 0;

  assign errors_o = mismatches;

  task automatic check_field(string name, int unsigned expv, int unsigned gotv);
    if (expv != gotv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      mismatches++;
    end
  endtask

  // track writes, predict on event transfer, compare on result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_model = lock_power_up();
      results_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        lock_model = lock_write_reg(lock_model, cfg_index_i, cfg_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result with no event outstanding: status %0d", out_item_i.status);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          check_field("status", due.status, out_item_i.status);
          check_field("relay_closed", due.relay_closed, out_item_i.relay_closed);
          check_field("digits_entered", due.digits_entered, out_item_i.digits_entered);
          check_field("mode", due.mode, out_item_i.mode);
          check_field("fail_count", due.fail_count, out_item_i.fail_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(lock_advance(lock_model, in_item_i));
      end
      pending_o <= results_due.size();
    end
  end

endmodule

>>> sim/tb_keypad_code_lock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_controller
// Drives the code lock with a short directed sequence (idle tick, unused
// kind, partial entry dropped by the reset button, code change to a code
// holding digits above nine) and then with model-steered random events over
// several register settings, from zero-length waits to the largest ones.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_controller;

  import kcl_pkg::*;
  import kcl_lock_model_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        ev_valid;
  logic        ev_ready;
  in_item_t    ev_item;
  logic        res_valid;
  logic        res_ready = 1'b0;
  out_item_t   res_item;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_data;

  int unsigned pending;
  int unsigned errors;

  lock_state_t lock_plan;
  logic        aim_right;
  logic        idle_on = 1'b1;
  logic [1:0]  stall_left = '0;
  logic        useful;
  in_item_t    opening[$];

  // code entered during the directed code change
  logic [3:0]  change_code [8] = '{4'd0, 4'd9, 4'd15, 4'd10, 4'd8, 4'd3, 4'd7, 4'd2};

  keypad_code_lock_controller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_ready_o  (ev_ready),
    .in_item_i   (ev_item),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_item_o  (res_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  kcl_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_ready_i  (ev_ready),
    .in_item_i   (ev_item),
    .out_valid_i (res_valid),
    .out_ready_i (res_ready),
    .out_item_i  (res_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 2'd1;
      res_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      stall_left <= 2'($urandom_range(0, 2));
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic in_item_t mk(logic [1:0] kind, logic [3:0] digit);
    in_item_t ev;
    ev.kind  = kind;
    ev.digit = digit;
    return ev;
  endfunction

  function automatic logic [3:0] any_digit();
    return ($urandom_range(0, 99) < 8) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
  endfunction

  // next event, steered by the planned lock state
  function automatic in_item_t pick_event();
    in_item_t    ev;
    int unsigned roll;
    logic [3:0]  want;
    roll     = $urandom_range(0, 99);
    ev.digit = any_digit();
    if (lock_busy(lock_plan)) begin
      ev.kind = (roll < 85) ? 2'(KindTick) : 2'($urandom_range(0, 3));
    end else if (roll < 5) begin
      ev.kind = KindTick;
    end else if (roll < 8) begin
      ev.kind = KindUnused;
    end else if (roll < 12) begin
      ev.kind = KindReset;
    end else begin
      ev.kind = KindDigit;
      if (lock_plan.pos == 0) aim_right = ($urandom_range(0, 99) < 60);
      case (lock_plan.mode)
        ModeNew:     want = ev.digit;
        ModeConfirm: want = lock_plan.fresh[lock_plan.pos];
        default:     want = lock_plan.code[lock_plan.pos];
      endcase
      if (aim_right || $urandom_range(0, 99) < 75) ev.digit = want;
    end
    return ev;
  endfunction

  // one event transfer; valid stays up for the caller to reuse or drop
  task automatic push_event(input in_item_t ev, output logic counts);
    out_item_t r;
    r        = lock_advance(lock_plan, ev);
    counts   = (r.status != StBusy);
    ev_valid <= 1'b1;
    ev_item  <= ev;
    do @(posedge clk); while (!ev_ready);
  endtask

  task automatic pause_input(int unsigned cycles);
    ev_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every predicted result has been seen
  task automatic drain();
    ev_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    lock_plan = lock_write_reg(lock_plan, idx, value);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [3:0] attempts, logic [15:0] lockout, logic [15:0] penalty,
                           logic [15:0] hold);
    write_reg(CfgMaxAttempts, 16'(attempts));
    write_reg(CfgLockoutTicks, lockout);
    write_reg(CfgPenaltyTicks, penalty);
    write_reg(CfgUnlockTicks, hold);
    cfg_valid <= 1'b0;
  endtask

  // random events until enough of them did something
  task automatic run_random(int unsigned target);
    int unsigned done;
    logic        counts;
    done = 0;
    while (done < target) begin
      if (idle_on && $urandom_range(0, 99) < 15) pause_input($urandom_range(1, 3));
      if (idle_on && $urandom_range(0, 999) < 5) drain();
      push_event(pick_event(), counts);
      if (counts) done++;
    end
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    ev_valid  = 1'b0;
    ev_item   = '0;
    cfg_valid = 1'b0;
    cfg_idx   = CfgMaxAttempts;
    cfg_data  = '0;
    rst_n     = 1'b0;
    aim_right = 1'b1;
    lock_plan = lock_power_up();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, unused kind, partial entry dropped by reset button
    opening.push_back(mk(KindTick, 4'd0));
    opening.push_back(mk(KindUnused, 4'd15));
    opening.push_back(mk(KindDigit, 4'd0));
    opening.push_back(mk(KindDigit, 4'd15));
    opening.push_back(mk(KindReset, 4'd0));
    opening.push_back(mk(KindReset, 4'd9));
    // old code, then a new code with digits above nine, entered twice
    for (int i = 0; i < CodeDigits; i++) opening.push_back(mk(KindDigit, CodeResetDigit));
    for (int i = 0; i < CodeDigits; i++) opening.push_back(mk(KindDigit, change_code[i]));
    for (int i = 0; i < CodeDigits; i++) opening.push_back(mk(KindDigit, change_code[i]));
    foreach (opening[i]) push_event(opening[i], useful);
    drain();

    // register settings, zero waits and the largest values among them
    configure(4'd1, 16'd0, 16'd0, 16'd0);
    run_random(300);
    drain();
    configure(4'd15, 16'd3, 16'd1, 16'd2);
    run_random(350);
    drain();
    configure(4'd2, 16'd7, 16'd2, 16'd0);
    run_random(350);
    drain();
    idle_on <= 1'b0;
    configure(4'd4, 16'd1, 16'd0, 16'd3);
    run_random(350);
    drain();
    configure(4'd1, 16'd65535, 16'd65535, 16'd65535);
    run_random(40);
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
